FILE: src/scope_trigger_capture_scaler_macros.svh
// assertion macros for the scope trigger capture scaler
// uses clk_i and rst_ni of the module that includes it
`ifndef SCOPE_TRIGGER_CAPTURE_SCALER_MACROS_SVH
`define SCOPE_TRIGGER_CAPTURE_SCALER_MACROS_SVH
`ifndef SYNTHESIS
`define STC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("stc assertion failed");
`define STC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stc assertion failed");
`else
`define STC_ASSERT(label, prop)
`define STC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/stc_pkg.sv
// shared types and constants of the scope trigger capture scaler
// no dependencies
`default_nettype none

package stc_pkg;

  localparam int FRAME_PAIRS = 512;
  localparam int CNT_W       = (FRAME_PAIRS > 1) ? $clog2(FRAME_PAIRS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_PAIRS - 1);

  localparam int ADC_W     = 12;
  localparam int LVL_W     = 12;
  localparam int HYS_W     = 11;
  localparam int MS_W      = 16;
  localparam int MV_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SYNC_W    = 32;

  localparam logic [SYNC_W-1:0] SYNC_WORD = 32'hDDCC_BBAA;

  localparam logic [LVL_W-1:0] LEVEL_RST   = 12'd2048;
  localparam logic [HYS_W-1:0] HYS_RST     = 11'd150;
  localparam logic [MS_W-1:0]  TIMEOUT_RST = 16'd50;

  // millivolt conversion: pin = s * 3300 / 4095
  localparam int MV_SCALE    = 3300;
  localparam int ADC_FULL    = 4095;
  localparam int MV_MID      = 1650;
  localparam int PROD_W      = 24;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 36;
  // floor(2^36 / 4095)
  localparam logic [RECIP_W-1:0] RECIP = 25'd16781313;

  localparam int PIPE_STAGES = 4;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int CRED_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL   = 3'd0,
    REG_HYST    = 3'd1,
    REG_FALLING = 3'd2,
    REG_NORMAL  = 3'd3,
    REG_AC      = 3'd4,
    REG_X10     = 3'd5,
    REG_TIMEOUT = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [HYS_W-1:0] hys;
    logic             falling;
    logic             normal;
    logic             ac;
    logic             x10;
    logic [MS_W-1:0]  timeout;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic hdr;
    logic data;
    logic last;
  } token_t;

endpackage

`default_nettype wire

FILE: src/scope_trigger_capture_scaler.sv
// Scope edge trigger with hysteresis, frame capture and millivolt scaling.
// Input channel (in_valid_i / in_stall_o): one transaction per cycle while not
// stalled, either a sample pair (kind_i = 0) or a millisecond tick (kind_i = 1).
// Output channel (out_valid_o / out_stall_i): sync headers and data results,
// each header followed by a frame of FRAME_PAIRS data results.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i;
// write only while no transaction is in flight.
// Each result passes the four-stage conversion lanes (two multiplies, a
// remainder correction and saturation) and then the result queue.
// Throughput: one input transaction per cycle while in_stall_o is low. Each
// trigger pair yields two results, so the output falls behind once per frame;
// an eight-entry queue absorbs that, and in_stall_o rises when eight
// result-bearing transactions sit in the lanes and the queue.
// Reset clears trigger state, the queue and the tick count and loads the
// register defaults. When the receiver stalls, the queue fills and the input
// then stalls; nothing is lost.
// depends on stc_pkg, stc_trig, stc_mv_lane, stc_merge and the macros header
`default_nettype none

`include "scope_trigger_capture_scaler_macros.svh"

module scope_trigger_capture_scaler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [stc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [stc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic        [stc_pkg::ADC_W-1:0]     sample_a_i,
  input  logic        [stc_pkg::ADC_W-1:0]     sample_b_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 is_header_o,
  output logic        [stc_pkg::SYNC_W-1:0]    sync_word_o,
  output logic signed [stc_pkg::MV_W-1:0]      millivolts_a_o,
  output logic signed [stc_pkg::MV_W-1:0]      millivolts_b_o,
  output logic                                 frame_last_o
);
  import stc_pkg::*;

  cfg_t   cfg_q, cfg_d;
  token_t tok;
  token_t pipe_q [PIPE_STAGES];

  logic [CRED_W-1:0] credit_q, credit_d;
  logic              accept;
  logic              launch;
  logic              pop;
  logic signed [MV_W-1:0] mv_a, mv_b;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LEVEL:   cfg_d.level   = cfg_wdata_i[LVL_W-1:0];
        REG_HYST:    cfg_d.hys     = cfg_wdata_i[HYS_W-1:0];
        REG_FALLING: cfg_d.falling = cfg_wdata_i[0];
        REG_NORMAL:  cfg_d.normal  = cfg_wdata_i[0];
        REG_AC:      cfg_d.ac      = cfg_wdata_i[0];
        REG_X10:     cfg_d.x10     = cfg_wdata_i[0];
        REG_TIMEOUT: cfg_d.timeout = cfg_wdata_i[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{level: LEVEL_RST, hys: HYS_RST, falling: 1'b0, normal: 1'b0,
                 ac: 1'b0, x10: 1'b0, timeout: TIMEOUT_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = (credit_q == CRED_W'(FIFO_DEPTH));
  assign accept     = in_valid_i & ~in_stall_o;
  assign launch     = accept & tok.valid;

  stc_trig u_trig (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (kind_i),
    .sample_a_i (sample_a_i),
    .cfg_i      (cfg_q),
    .tok_o      (tok)
  );

  stc_mv_lane u_lane_a (
    .clk_i    (clk_i),
    .sample_i (sample_a_i),
    .ac_i     (cfg_q.ac),
    .x10_i    (cfg_q.x10),
    .mv_o     (mv_a)
  );

  stc_mv_lane u_lane_b (
    .clk_i    (clk_i),
    .sample_i (sample_b_i),
    .ac_i     (cfg_q.ac),
    .x10_i    (cfg_q.x10),
    .mv_o     (mv_b)
  );

  // token travels alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        pipe_q[i] <= '0;
      end
    end else begin
      pipe_q[0] <= tok;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  stc_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (pipe_q[PIPE_STAGES-1].valid),
    .tok_i          (pipe_q[PIPE_STAGES-1]),
    .mv_a_i         (mv_a),
    .mv_b_i         (mv_b),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_header_o    (is_header_o),
    .sync_word_o    (sync_word_o),
    .millivolts_a_o (millivolts_a_o),
    .millivolts_b_o (millivolts_b_o),
    .frame_last_o   (frame_last_o),
    .pop_o          (pop)
  );

  // entries in the lanes plus entries in the queue
  assign credit_d = credit_q + CRED_W'(launch) - CRED_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  `STC_ASSERT(credit_bound, credit_q <= CRED_W'(FIFO_DEPTH))
  `STC_ASSERT(valid_has_credit, !out_valid_o || (credit_q != '0))
  `STC_ASSERT_NEXT(pop_frees_credit, pop && !launch, credit_q == CRED_W'($past(credit_q) - 1'b1))
  `STC_ASSERT(token_in_flight, !pipe_q[PIPE_STAGES-1].valid || (credit_q != '0))

endmodule

`default_nettype wire

FILE: src/stc_mv_lane.sv
// one conversion lane: adc counts to millivolts, four register stages
// depends on stc_pkg
`default_nettype none

module stc_mv_lane (
  input  logic                               clk_i,
  input  logic        [stc_pkg::ADC_W-1:0]   sample_i,
  input  logic                               ac_i,
  input  logic                               x10_i,
  output logic signed [stc_pkg::MV_W-1:0]    mv_o
);
  import stc_pkg::*;

  localparam int FULL_W = PROD_W + RECIP_W;
  localparam int P2_W   = ADC_W + 2;
  localparam int X10_W  = P2_W + 4;

  logic [PROD_W-1:0] x_q;
  logic [PROD_W-1:0] x2_q;
  logic [ADC_W-1:0]  q0_q;
  logic [ADC_W-1:0]  pin_q;
  logic signed [MV_W-1:0] mv_q;

  logic [FULL_W-1:0] prod;
  logic [PROD_W-1:0] rem;
  logic [ADC_W-1:0]  pin_d;
  logic signed [P2_W-1:0]  p2;
  logic signed [P2_W-1:0]  mv_base;
  logic signed [X10_W-1:0] mv_wide;
  logic signed [X10_W-1:0] mv_ten;
  logic signed [MV_W-1:0]  mv_d;

  // reciprocal estimate is exact or one short
  assign prod = FULL_W'(x_q) * FULL_W'(RECIP);
  assign rem  = x2_q - PROD_W'(PROD_W'(q0_q) * PROD_W'(ADC_FULL));

  always_comb begin
    pin_d = (rem >= PROD_W'(ADC_FULL)) ? q0_q + 1'b1 : q0_q;
  end

  always_comb begin
    p2      = $signed({1'b0, pin_q, 1'b0});
    mv_base = ac_i ? p2 - P2_W'(2 * MV_MID) : p2 - P2_W'(MV_MID);
    mv_wide = X10_W'(mv_base);
    mv_ten  = (mv_wide <<< 3) + (mv_wide <<< 1);
    if (!x10_i) begin
      mv_d = MV_W'(mv_base);
    end else if (mv_ten > X10_W'(32767)) begin
      mv_d = 16'sh7FFF;
    end else if (mv_ten < -X10_W'(32768)) begin
      mv_d = 16'sh8000;
    end else begin
      mv_d = MV_W'(mv_ten);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= PROD_W'(PROD_W'(sample_i) * PROD_W'(MV_SCALE));
    x2_q  <= x_q;
    q0_q  <= prod[RECIP_SHIFT +: ADC_W];
    pin_q <= pin_d;
    mv_q  <= mv_d;
  end

  assign mv_o = mv_q;

endmodule

`default_nettype wire

FILE: src/stc_trig.sv
// trigger search, auto timeout and frame counting; one decision per transaction
// depends on stc_pkg
`default_nettype none

module stc_trig (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       kind_i,
  input  logic [stc_pkg::ADC_W-1:0]  sample_a_i,
  input  stc_pkg::cfg_t              cfg_i,
  output stc_pkg::token_t            tok_o
);
  import stc_pkg::*;

  localparam int CMP_W = LVL_W + 2;

  logic             armed_q, armed_d;
  logic             capturing_q, capturing_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [MS_W-1:0]  ms_q, ms_d;

  logic [MS_W-1:0]         ms_inc;
  logic signed [CMP_W-1:0] lo, hi, v;
  logic                    arm_n, fire;

  always_comb begin
    lo = $signed({2'b00, cfg_i.level}) - $signed({3'b000, cfg_i.hys});
    hi = $signed({2'b00, cfg_i.level}) + $signed({3'b000, cfg_i.hys});
    v  = $signed({2'b00, sample_a_i});
    if (!cfg_i.falling) begin
      arm_n = armed_q | (v < lo);
      fire  = arm_n & (v >= hi);
    end else begin
      arm_n = armed_q | (v > hi);
      fire  = arm_n & (v <= lo);
    end
  end

  assign ms_inc = (ms_q == '1) ? ms_q : ms_q + 1'b1;

  always_comb begin
    armed_d     = armed_q;
    capturing_d = capturing_q;
    count_d     = count_q;
    ms_d        = ms_q;
    tok_o       = '0;
    if (accept_i) begin
      if (kind_i == KIND_TICK) begin
        ms_d = ms_inc;
        if (!capturing_q && !cfg_i.normal && (ms_inc > cfg_i.timeout)) begin
          tok_o.valid = 1'b1;
          tok_o.hdr   = 1'b1;
          capturing_d = 1'b1;
          count_d     = '0;
          ms_d        = '0;
        end
      end else if (capturing_q) begin
        tok_o.valid = 1'b1;
        tok_o.data  = 1'b1;
        if (count_q == CNT_LAST) begin
          tok_o.last  = 1'b1;
          capturing_d = 1'b0;
          count_d     = '0;
        end else begin
          count_d     = count_q + 1'b1;
        end
      end else begin
        armed_d = arm_n;
        if (fire) begin
          // trigger pair is the first pair of the frame
          armed_d     = 1'b0;
          ms_d        = '0;
          tok_o.valid = 1'b1;
          tok_o.hdr   = 1'b1;
          tok_o.data  = 1'b1;
          if (CNT_LAST == '0) begin
            tok_o.last  = 1'b1;
            capturing_d = 1'b0;
            count_d     = '0;
          end else begin
            capturing_d = 1'b1;
            count_d     = CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      capturing_q <= 1'b0;
      count_q     <= '0;
      ms_q        <= '0;
    end else begin
      armed_q     <= armed_d;
      capturing_q <= capturing_d;
      count_q     <= count_d;
      ms_q        <= ms_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/stc_merge.sv
// merges lane results with their control token into a result queue,
// then sends the header and data of each entry in turn; depends on stc_pkg
`default_nettype none

module stc_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  stc_pkg::token_t                    tok_i,
  input  logic signed [stc_pkg::MV_W-1:0]    mv_a_i,
  input  logic signed [stc_pkg::MV_W-1:0]    mv_b_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               is_header_o,
  output logic        [stc_pkg::SYNC_W-1:0]  sync_word_o,
  output logic signed [stc_pkg::MV_W-1:0]    millivolts_a_o,
  output logic signed [stc_pkg::MV_W-1:0]    millivolts_b_o,
  output logic                               frame_last_o,
  output logic                               pop_o
);
  import stc_pkg::*;

  typedef struct packed {
    logic                   hdr;
    logic                   data;
    logic                   last;
    logic signed [MV_W-1:0] mva;
    logic signed [MV_W-1:0] mvb;
  } entry_t;

  entry_t mem_q [FIFO_DEPTH];

  logic [FIFO_AW-1:0] wr_q, wr_d;
  logic [FIFO_AW-1:0] rd_q, rd_d;
  logic [CRED_W-1:0]  cnt_q, cnt_d;
  logic               hdr_done_q, hdr_done_d;

  entry_t head;
  logic   show_hdr;
  logic   take;

  assign head        = mem_q[rd_q];
  assign out_valid_o = (cnt_q != '0);
  assign show_hdr    = head.hdr & ~hdr_done_q;
  assign take        = out_valid_o & ~out_stall_i;
  // an entry leaves once its data went out, or after a header-only transaction
  assign pop_o       = take & (~show_hdr | ~head.data);

  assign is_header_o    = show_hdr;
  assign sync_word_o    = show_hdr ? SYNC_WORD : '0;
  assign millivolts_a_o = show_hdr ? '0 : head.mva;
  assign millivolts_b_o = show_hdr ? '0 : head.mvb;
  assign frame_last_o   = ~show_hdr & head.last;

  always_comb begin
    wr_d       = push_i ? wr_q + 1'b1 : wr_q;
    rd_d       = pop_o ? rd_q + 1'b1 : rd_q;
    cnt_d      = cnt_q + CRED_W'(push_i) - CRED_W'(pop_o);
    hdr_done_d = hdr_done_q;
    if (take) begin
      hdr_done_d = ~pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= '{hdr: tok_i.hdr, data: tok_i.data, last: tok_i.last,
                       mva: mv_a_i, mvb: mv_b_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
      hdr_done_q <= 1'b0;
    end else begin
      wr_q       <= wr_d;
      rd_q       <= rd_d;
      cnt_q      <= cnt_d;
      hdr_done_q <= hdr_done_d;
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_scope_trigger_capture_scaler.sv
`timescale 1ns / 1ps
// testbench for scope_trigger_capture_scaler: directed and random sample and tick
// transactions over many register phases, checked against a scoreboard that predicts
// headers and millivolt frames; depends on stc_pkg and the rtl of the block

module tb_scope_trigger_capture_scaler;
  import stc_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TARGET_ITEMS = 750;

  typedef struct packed {
    logic                   hdr;
    logic [SYNC_W-1:0]      sync;
    logic signed [MV_W-1:0] mv_a;
    logic signed [MV_W-1:0] mv_b;
    logic                   last;
  } mv_result_t;

  class frame_scoreboard;
    cfg_t            cfg;
    logic            armed;
    logic            capturing;
    int              pairs_in_frame;
    logic [MS_W-1:0] ms_count;
    mv_result_t      mv_due[$];
    int              errors;
    int              items;
    int              edge_trigs;
    int              forced_trigs;
    int              data_seen;
    int              frames_done;

    function new();
      cfg = '0;
      cfg.level = LEVEL_RST;
      cfg.hys = HYS_RST;
      cfg.timeout = TIMEOUT_RST;
      armed = 1'b0;
      capturing = 1'b0;
      pairs_in_frame = 0;
      ms_count = '0;
      errors = 0;
      items = 0;
      edge_trigs = 0;
      forced_trigs = 0;
      data_seen = 0;
      frames_done = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_LEVEL:   cfg.level = v[LVL_W-1:0];
        REG_HYST:    cfg.hys = v[HYS_W-1:0];
        REG_FALLING: cfg.falling = v[0];
        REG_NORMAL:  cfg.normal = v[0];
        REG_AC:      cfg.ac = v[0];
        REG_X10:     cfg.x10 = v[0];
        REG_TIMEOUT: cfg.timeout = v[MS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [MV_W-1:0] scale_to_mv(logic [ADC_W-1:0] s);
      int pin;
      int mv;
      pin = (int'(s) * MV_SCALE) / ADC_FULL;
      mv = cfg.ac ? (pin - MV_MID) * 2 : pin * 2 - MV_MID;
      if (cfg.x10) begin
        mv = mv * 10;
        if (mv > 32767) mv = 32767;
        if (mv < -32768) mv = -32768;
      end
      return mv[MV_W-1:0];
    endfunction

    function void push_data(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
      mv_result_t r;
      r = '0;
      r.mv_a = scale_to_mv(a);
      r.mv_b = scale_to_mv(b);
      pairs_in_frame++;
      if (pairs_in_frame >= FRAME_PAIRS) begin
        r.last = 1'b1;
        capturing = 1'b0;
        pairs_in_frame = 0;
        frames_done++;
      end else begin
        capturing = 1'b1;
      end
      mv_due.push_back(r);
    endfunction

    // returns the number of results the transaction causes
    function int note_item(kind_e k, logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
      int lo;
      int hi;
      int v;
      bit fire;
      mv_result_t h;
      items++;
      h = '0;
      h.hdr = 1'b1;
      h.sync = SYNC_WORD;
      if (k == KIND_TICK) begin
        if (ms_count != '1) ms_count++;
        if (!capturing && !cfg.normal && ms_count > cfg.timeout) begin
          mv_due.push_back(h);
          capturing = 1'b1;
          pairs_in_frame = 0;
          ms_count = '0;
          forced_trigs++;
          return 1;
        end
        return 0;
      end
      if (capturing) begin
        push_data(a, b);
        return 1;
      end
      // low threshold may go negative, compared signed
      lo = int'(cfg.level) - int'(cfg.hys);
      hi = int'(cfg.level) + int'(cfg.hys);
      v = int'(a);
      fire = 1'b0;
      if (!cfg.falling) begin
        if (v < lo) armed = 1'b1;
        if (armed && v >= hi) fire = 1'b1;
      end else begin
        if (v > hi) armed = 1'b1;
        if (armed && v <= lo) fire = 1'b1;
      end
      if (!fire) return 0;
      armed = 1'b0;
      ms_count = '0;
      pairs_in_frame = 0;
      edge_trigs++;
      mv_due.push_back(h);
      push_data(a, b);
      return 2;
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(mv_result_t got);
      mv_result_t want;
      if (mv_due.size() == 0) begin
        errors++;
        $display("%0t: result %h with nothing expected", $time, got);
        return;
      end
      want = mv_due.pop_front();
      if (!want.hdr) data_seen++;
      report_field("is_header", 32'(want.hdr), 32'(got.hdr));
      report_field("sync_word", want.sync, got.sync);
      report_field("millivolts_a", 32'(want.mv_a), 32'(got.mv_a));
      report_field("millivolts_b", 32'(want.mv_b), 32'(got.mv_b));
      report_field("frame_last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 kind_i = 1'b0;
  logic [ADC_W-1:0]     sample_a_i = '0;
  logic [ADC_W-1:0]     sample_b_i = '0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 is_header_o;
  logic [SYNC_W-1:0]    sync_word_o;
  logic signed [MV_W-1:0] millivolts_a_o;
  logic signed [MV_W-1:0] millivolts_b_o;
  logic                 frame_last_o;

  frame_scoreboard frames;
  int              tx_mode = 1;
  int              rx_mode = 1;
  int unsigned     stall_left = 0;
  int unsigned     rx_wait;
  int              idle_cycles = 0;
  int              phases = 0;

  scope_trigger_capture_scaler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .sample_a_i     (sample_a_i),
    .sample_b_i     (sample_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_header_o    (is_header_o),
    .sync_word_o    (sync_word_o),
    .millivolts_a_o (millivolts_a_o),
    .millivolts_b_o (millivolts_b_o),
    .frame_last_o   (frame_last_o)
  );

  always #6 clk_i = ~clk_i;

  // 0: no idling, 1: full range, 2: mostly back to back
  function automatic int unsigned draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  // result side: check accepted transactions, stall for a drawn count after each
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        frames.check_result({is_header_o, sync_word_o, millivolts_a_o, millivolts_b_o,
                             frame_last_o});
      end
      if (out_stall_i) begin
        if (stall_left == 0) out_stall_i <= 1'b0;
        else stall_left <= stall_left - 1;
      end else if (out_valid_o) begin
        rx_wait = draw_gap(rx_mode);
        if (rx_wait > 0) begin
          out_stall_i <= 1'b1;
          stall_left <= rx_wait - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_scope_trigger_capture_scaler NOT OK");
      $finish;
    end
  end

  task automatic send_item(kind_e k, logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
    int unsigned gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    sample_a_i <= a;
    sample_b_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    void'(frames.note_item(k, a, b));
  endtask

  // leaves the write enable high, the caller lowers it after the last write
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    frames.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic write_regs(bit all_regs);
    logic [CFG_W-1:0] v;
    int w;
    for (int i = 0; i <= int'(REG_TIMEOUT); i++) begin
      if (all_regs || $urandom_range(0, 1) == 1) begin
        case (cfg_reg_e'(i))
          REG_LEVEL: begin
            w = LVL_W;
            case ($urandom_range(0, 5))
              0: v = '0;
              1: v = CFG_W'(ADC_FULL);
              default: v = CFG_W'($urandom_range(0, ADC_FULL));
            endcase
          end
          REG_HYST: begin
            w = HYS_W;
            case ($urandom_range(0, 5))
              0: v = '0;
              1: v = CFG_W'(2047);
              2: v = CFG_W'($urandom_range(0, 2047));
              default: v = CFG_W'($urandom_range(0, 300));
            endcase
          end
          REG_TIMEOUT: begin
            w = MS_W;
            case ($urandom_range(0, 5))
              0: v = '0;
              1: v = '1;
              default: v = CFG_W'($urandom_range(0, 40));
            endcase
          end
          default: begin
            w = 1;
            v = CFG_W'($urandom_range(0, 1));
          end
        endcase
        // junk above the register width must be ignored
        v = v | (CFG_W'($urandom) << w);
        write_reg(cfg_reg_e'(i), v);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // wait for every expected result, then cover results still in the pipe
  task automatic settle();
    in_valid_i <= 1'b0;
    while (frames.mv_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random(int tick_pct);
    int lo;
    int hi;
    int r;
    logic [ADC_W-1:0] a;
    logic [ADC_W-1:0] b;
    a = ADC_W'($urandom);
    b = ADC_W'($urandom);
    r = $urandom_range(0, 99);
    lo = int'(frames.cfg.level) - int'(frames.cfg.hys);
    hi = int'(frames.cfg.level) + int'(frames.cfg.hys);
    if (r < tick_pct) begin
      send_item(KIND_TICK, a, b);
    end else begin
      if (frames.capturing) begin
        if ($urandom_range(0, 4) == 0) a = ($urandom_range(0, 1) == 1) ? '1 : '0;
        if ($urandom_range(0, 4) == 0) b = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end else if (r >= tick_pct + 10) begin
        // mostly a well-formed arm then fire sequence
        if (!frames.cfg.falling) begin
          if (!frames.armed && lo > 0) a = ADC_W'($urandom_range(0, lo - 1));
          else if (frames.armed && hi <= ADC_FULL && $urandom_range(0, 9) < 7)
            a = ADC_W'($urandom_range(hi, ADC_FULL));
        end else begin
          if (!frames.armed && hi < ADC_FULL) a = ADC_W'($urandom_range(hi + 1, ADC_FULL));
          else if (frames.armed && lo >= 0 && $urandom_range(0, 9) < 7)
            a = ADC_W'($urandom_range(0, lo));
        end
      end
      send_item(KIND_SAMPLE, a, b);
    end
  endtask

  initial begin
    int tick_pct;
    frames = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // low threshold below zero: rising edge can neither arm nor fire
    write_reg(REG_LEVEL, 16'd100);
    write_reg(REG_HYST, 16'd2047);
    write_reg(REG_TIMEOUT, 16'd0);
    cfg_we_i <= 1'b0;
    send_item(KIND_SAMPLE, 12'd0, 12'd4095);
    send_item(KIND_SAMPLE, 12'd4095, 12'd0);
    // forced trigger, header alone, frame starts with the next pair
    send_item(KIND_TICK, 12'd0, 12'd0);
    send_item(KIND_SAMPLE, 12'd0, 12'd4095);
    send_item(KIND_SAMPLE, 12'd4095, 12'd0);
    send_item(KIND_TICK, 12'd4095, 12'd4095);
    send_item(KIND_TICK, 12'd0, 12'd0);
    send_item(KIND_SAMPLE, 12'd2048, 12'd2047);
    settle();
    // scaling changes in mid frame, saturation of the x10 probe
    write_reg(REG_AC, 16'd1);
    write_reg(REG_X10, 16'd1);
    cfg_we_i <= 1'b0;
    send_item(KIND_SAMPLE, 12'd4095, 12'd0);
    send_item(KIND_SAMPLE, 12'd0, 12'd4095);
    send_item(KIND_SAMPLE, 12'd1, 12'd4094);
    settle();
    write_reg(REG_AC, 16'd0);
    cfg_we_i <= 1'b0;
    send_item(KIND_SAMPLE, 12'd4095, 12'd0);
    send_item(KIND_SAMPLE, 12'd0, 12'd4095);
    send_item(KIND_SAMPLE, 12'd2730, 12'd1365);

    while (frames.items < TARGET_ITEMS) begin
      settle();
      write_regs(phases == 0);
      phases++;
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      tick_pct = $urandom_range(3, 30);
      repeat ($urandom_range(20, 120)) send_random(tick_pct);
    end
    settle();
    if (frames.mv_due.size() != 0) begin
      frames.errors++;
      $display("%0t: %0d results never arrived", $time, frames.mv_due.size());
    end

    $display("covered %0d transactions: %0d edge and %0d forced triggers, %0d data results,",
             frames.items, frames.edge_trigs, frames.forced_trigs, frames.data_seen);
    $display("%0d full frames, over %0d register phases", frames.frames_done, phases);
    if (frames.errors == 0) begin
      $display("tb_scope_trigger_capture_scaler OK");
    end else begin
      $display("tb_scope_trigger_capture_scaler NOT OK");
    end
    $finish;
  end

endmodule
